>>> rtl/core/vec4_safe_normalise_macros.svh
// Assertion macros for the vector normalizer
`ifndef VEC4_SAFE_NORMALISE_MACROS_SVH
`define VEC4_SAFE_NORMALISE_MACROS_SVH

// same-cycle implication, disabled in reset
`define VSN_AST_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define VSN_AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/vsn_pkg.sv
// Shared constants and types for the vector normalizer
package vsn_pkg;
  localparam int CW  = 16;          // component width
  localparam int NW  = 15;          // unsigned result magnitude width (0..16384)
  localparam int NB  = NW;          // result bits resolved, one per lane stage
  localparam int SQW = 31;          // square of one magnitude
  localparam int SW  = 33;          // sum of four squares
  localparam int QW  = 50;          // running u*S, signed
  localparam int PW  = 67;          // running u^2*S and bound, signed
  localparam int RSH = 30;          // bound shift: 4 * 2^28
  localparam int LANES = 4;
  localparam int LAT = NB + 3;      // front two stages, lane stages, output stage
  localparam logic [CW-1:0] ONE_Q14 = 16'd16384;

  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             zero;
  } vsn_flags_t;
endpackage

>>> rtl/core/vsn_if.sv
// Stream interfaces for vector words in and unit vector words out
interface vsn_in_if;
  logic                  valid;
  logic                  ready;
  logic [vsn_pkg::CW-1:0] comp_x;
  logic [vsn_pkg::CW-1:0] comp_y;
  logic [vsn_pkg::CW-1:0] comp_z;
  logic [vsn_pkg::CW-1:0] comp_w;
  modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface vsn_out_if;
  logic                  valid;
  logic                  ready;
  logic [vsn_pkg::CW-1:0] unit_x;
  logic [vsn_pkg::CW-1:0] unit_y;
  logic [vsn_pkg::CW-1:0] unit_z;
  logic [vsn_pkg::CW-1:0] unit_w;
  logic                  was_zero;
  modport source (output valid, unit_x, unit_y, unit_z, unit_w, was_zero, input ready);
  modport sink (input valid, unit_x, unit_y, unit_z, unit_w, was_zero, output ready);
endinterface

>>> rtl/core/vsn_front.sv
// Front end: magnitudes, squares and their sum
module vsn_front (
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  logic [vsn_pkg::CW-1:0]        comp [vsn_pkg::LANES],
  output logic [vsn_pkg::SQW-1:0]       asq [vsn_pkg::LANES],
  output logic [vsn_pkg::SW-1:0]        ssum,
  output vsn_pkg::vsn_flags_t           flags
);
  logic [vsn_pkg::SQW-1:0] sq [vsn_pkg::LANES];
  logic [vsn_pkg::LANES-1:0] neg;
  logic [vsn_pkg::CW-1:0] mag [vsn_pkg::LANES];
  logic [vsn_pkg::SW-1:0] sum_next;

  always_comb begin
    for (int i = 0; i < vsn_pkg::LANES; i++) begin
      mag[i] = comp[i][vsn_pkg::CW-1] ? vsn_pkg::CW'(-comp[i]) : comp[i];
    end
    sum_next = '0;
    for (int i = 0; i < vsn_pkg::LANES; i++) begin
      sum_next = sum_next + vsn_pkg::SW'(sq[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < vsn_pkg::LANES; i++) begin
        sq[i]  <= vsn_pkg::SQW'(mag[i]) * vsn_pkg::SQW'(mag[i]);
        neg[i] <= comp[i][vsn_pkg::CW-1];
      end
    end
    if (en[1]) begin
      asq        <= sq;
      ssum       <= sum_next;
      flags.neg  <= neg;
      flags.zero <= (sum_next == '0);
    end
  end
endmodule

>>> rtl/core/vsn_lane.sv
// One lane: bit-per-stage search of the rounded unit magnitude
module vsn_lane (
  input  logic                      clk,
  input  logic [vsn_pkg::NB-1:0]    en,
  input  logic [vsn_pkg::SQW-1:0]   asq,
  input  logic [vsn_pkg::SW-1:0]    ssum,
  output logic [vsn_pkg::NW-1:0]    mag
);
  // u = 2n-1; p = u^2*S, q = u*S kept exactly, updated with shifts and adds
  logic signed [vsn_pkg::PW-1:0] p [vsn_pkg::NB+1];
  logic signed [vsn_pkg::QW-1:0] q [vsn_pkg::NB+1];
  logic [vsn_pkg::NW-1:0]        n [vsn_pkg::NB+1];
  logic [vsn_pkg::SQW-1:0]       a2 [vsn_pkg::NB+1];
  logic [vsn_pkg::SW-1:0]        s [vsn_pkg::NB+1];

  assign p[0]  = $signed(vsn_pkg::PW'(ssum));
  assign q[0]  = -$signed(vsn_pkg::QW'(ssum));
  assign n[0]  = '0;
  assign a2[0] = asq;
  assign s[0]  = ssum;
  assign mag   = n[vsn_pkg::NB];

  for (genvar j = 0; j < vsn_pkg::NB; j++) begin : g_stg
    localparam int K = vsn_pkg::NB - 1 - j;
    logic signed [vsn_pkg::PW-1:0] cand;
    logic signed [vsn_pkg::PW-1:0] bound;
    logic                          take;

    assign cand = p[j] + (vsn_pkg::PW'(q[j]) <<< (K + 2))
                + $signed(vsn_pkg::PW'(s[j]) << (2 * K + 2));
    assign bound = $signed(vsn_pkg::PW'(a2[j]) << vsn_pkg::RSH);
    assign take  = (cand <= bound);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        a2[j+1] <= a2[j];
        s[j+1]  <= s[j];
        if (take) begin
          p[j+1] <= cand;
          q[j+1] <= q[j] + $signed(vsn_pkg::QW'(s[j]) << (K + 1));
          n[j+1] <= n[j] | vsn_pkg::NW'(1 << K);
        end else begin
          p[j+1] <= p[j];
          q[j+1] <= q[j];
          n[j+1] <= n[j];
        end
      end
    end
  end
endmodule

>>> rtl/core/vec4_safe_normalise.sv
// Top level of the four-component vector normalizer
//   channel  dir  fields
//   in_ch    in   comp_x comp_y comp_z comp_w (signed 16)
//   out_ch   out  unit_x unit_y unit_z unit_w (Q2.14) was_zero
// One word per cycle sustained while out_ch is ready; 2 front, 15 search and 1 output stage.
// The search runs in 15 bit-resolving stages in each of the four lanes.
// Each stage holds its word until the next stage frees; bubbles close up.
// Synchronous reset clears valid bits only.
`include "vec4_safe_normalise_macros.svh"
module vec4_safe_normalise (
  input logic       clk,
  input logic       rst,
  vsn_in_if.sink    in_ch,
  vsn_out_if.source out_ch
);
  localparam int L = vsn_pkg::LAT;

  logic [L-1:0] v;
  logic [L:0]   en;
  logic [vsn_pkg::CW-1:0]  comp [vsn_pkg::LANES];
  logic [vsn_pkg::SQW-1:0] asq [vsn_pkg::LANES];
  logic [vsn_pkg::SW-1:0]  ssum;
  logic [vsn_pkg::NW-1:0]  mag [vsn_pkg::LANES];
  vsn_pkg::vsn_flags_t     fl [vsn_pkg::NB+1];
  logic [vsn_pkg::CW-1:0]  res [vsn_pkg::LANES];
  logic                    zero_ok;

  assign en[L] = out_ch.ready;
  for (genvar i = 0; i < L; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end
  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_ch.valid;
      end
      for (int i = 1; i < L; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign comp[0] = in_ch.comp_x;
  assign comp[1] = in_ch.comp_y;
  assign comp[2] = in_ch.comp_z;
  assign comp[3] = in_ch.comp_w;

  vsn_front u_front (
    .clk   (clk),
    .en    (en[1:0]),
    .comp  (comp),
    .asq   (asq),
    .ssum  (ssum),
    .flags (fl[0])
  );

  for (genvar i = 0; i < vsn_pkg::LANES; i++) begin : g_lane
    vsn_lane u_lane (
      .clk  (clk),
      .en   (en[vsn_pkg::NB+1:2]),
      .asq  (asq[i]),
      .ssum (ssum),
      .mag  (mag[i])
    );
  end

  for (genvar j = 0; j < vsn_pkg::NB; j++) begin : g_fl
    always_ff @(posedge clk) begin
      if (en[j+2]) begin
        fl[j+1] <= fl[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < vsn_pkg::LANES; i++) begin
      if (fl[vsn_pkg::NB].zero) begin
        res[i] = (i == 0) ? vsn_pkg::ONE_Q14 : '0;
      end else if (fl[vsn_pkg::NB].neg[i]) begin
        res[i] = vsn_pkg::CW'(-vsn_pkg::CW'(mag[i]));
      end else begin
        res[i] = vsn_pkg::CW'(mag[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[L-1]) begin
      out_ch.unit_x   <= res[0];
      out_ch.unit_y   <= res[1];
      out_ch.unit_z   <= res[2];
      out_ch.unit_w   <= res[3];
      out_ch.was_zero <= fl[vsn_pkg::NB].zero;
    end
  end
  assign out_ch.valid = v[L-1];

  assign zero_ok = out_ch.unit_x == vsn_pkg::ONE_Q14 && out_ch.unit_y == '0 &&
                   out_ch.unit_z == '0 && out_ch.unit_w == '0;

  `VSN_AST_NEXT(a_accept_fill, in_ch.valid && in_ch.ready, v[0], "accepted word not captured")
  `VSN_AST_NOW(a_zero_vec, out_ch.valid && out_ch.was_zero, zero_ok, "bad zero default")
  `VSN_AST_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid, "output word lost")
endmodule

>>> tb/testbench.sv
// Self-checking testbench for vec4_safe_normalise: directed table plus random vectors
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [vsn_pkg::CW-1:0] comp_t;

  typedef struct {
    comp_t c[4];
  } vec_t;

  typedef struct {
    comp_t u[4];
    logic  zero;
  } unit_t;

  typedef struct {
    vec_t  v;
    bit    typed;
    unit_t want;
  } word_t;

  localparam comp_t P1 = comp_t'(vsn_pkg::ONE_Q14);
  localparam comp_t N1 = -comp_t'(vsn_pkg::ONE_Q14);
  localparam comp_t HALF = comp_t'(vsn_pkg::ONE_Q14 / 2);

  logic clk = 1'b0;
  logic rst = 1'b1;

  vsn_in_if  in_ch ();
  vsn_out_if out_ch ();

  vec4_safe_normalise u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  word_t pending_words[$];
  unit_t expected_units[$];
  int    errors = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  // round-half-up of a*16384/sqrt(s), by comparing squares
  function automatic logic [15:0] scale_mag(longint unsigned a, longint unsigned s);
    longint unsigned bound;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned t;
    bound = (a * a) << vsn_pkg::RSH;
    lo = 0;
    hi = vsn_pkg::ONE_Q14;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      t = 2 * mid - 1;
      if (t * t * s <= bound) lo = mid;
      else hi = mid - 1;
    end
    return lo[15:0];
  endfunction

  function automatic unit_t normalize(vec_t v);
    unit_t r;
    longint unsigned mag[4];
    longint unsigned s;
    logic [15:0] n;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = v.c[i] < 0 ? longint'(-int'(v.c[i])) : longint'(v.c[i]);
      s += mag[i] * mag[i];
    end
    if (s == 0) begin
      r.u[0] = P1;
      for (int i = 1; i < 4; i++) r.u[i] = '0;
      r.zero = 1'b1;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      n = scale_mag(mag[i], s);
      r.u[i] = v.c[i] < 0 ? -comp_t'(n) : comp_t'(n);
    end
    r.zero = 1'b0;
    return r;
  endfunction

  function automatic word_t mk(comp_t x, comp_t y, comp_t z, comp_t w, bit typed = 0,
                               comp_t ex = 0, comp_t ey = 0, comp_t ez = 0,
                               comp_t ew = 0, logic ezero = 0);
    word_t r;
    r.v.c = '{x, y, z, w};
    r.typed = typed;
    r.want.u = '{ex, ey, ez, ew};
    r.want.zero = ezero;
    return r;
  endfunction

  function automatic comp_t rand_comp(int mode);
    case (mode)
      0: return comp_t'($urandom);
      1: return comp_t'($urandom_range(0, 16) - 8);
      2: return comp_t'($urandom_range(0, 512) - 256);
      default: return $urandom_range(0, 1) ? comp_t'(16'h8000) : comp_t'(16'h7fff);
    endcase
  endfunction

  function automatic word_t rand_word();
    word_t r;
    int mode;
    int lone;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) r.v.c[i] = rand_comp(mode < 5 ? 0 : mode - 5);
    if ($urandom_range(0, 5) == 0) begin
      lone = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) if (i != lone) r.v.c[i] = '0;
    end
    if ($urandom_range(0, 40) == 0) r.v.c = '{default: '0};
    r.typed = 0;
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.comp_x = '0;
    in_ch.comp_y = '0;
    in_ch.comp_z = '0;
    in_ch.comp_w = '0;
    out_ch.ready = 1'b0;
  end

  // sender: one word per accept, random gaps
  always @(posedge clk) begin
    word_t wd;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        wd = pending_words.pop_front();
        expected_units.push_back(wd.typed ? wd.want : normalize(wd.v));
      end
      if (pending_words.size() > 0 && ($urandom_range(0, 99) >= send_idle_pct ||
          (in_ch.valid && !in_ch.ready))) begin
        wd = pending_words[0];
        in_ch.valid <= 1'b1;
        in_ch.comp_x <= wd.v.c[0];
        in_ch.comp_y <= wd.v.c[1];
        in_ch.comp_z <= wd.v.c[2];
        in_ch.comp_w <= wd.v.c[3];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, check each accepted word
  always @(posedge clk) begin
    unit_t got;
    unit_t exp_u;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got.u = '{out_ch.unit_x, out_ch.unit_y, out_ch.unit_z, out_ch.unit_w};
        got.zero = out_ch.was_zero;
        if (expected_units.size() == 0) begin
          $error("unexpected output word");
          errors++;
        end else begin
          exp_u = expected_units.pop_front();
          if (got.u[0] !== exp_u.u[0]) begin
            $error("unit_x expected %0d got %0d", exp_u.u[0], got.u[0]); errors++;
          end
          if (got.u[1] !== exp_u.u[1]) begin
            $error("unit_y expected %0d got %0d", exp_u.u[1], got.u[1]); errors++;
          end
          if (got.u[2] !== exp_u.u[2]) begin
            $error("unit_z expected %0d got %0d", exp_u.u[2], got.u[2]); errors++;
          end
          if (got.u[3] !== exp_u.u[3]) begin
            $error("unit_w expected %0d got %0d", exp_u.u[3], got.u[3]); errors++;
          end
          if (got.zero !== exp_u.zero) begin
            $error("was_zero expected %0d got %0d", exp_u.zero, got.zero); errors++;
          end
        end
      end
      out_ch.ready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    word_t directed[$];
    directed = '{
      mk(0, 0, 0, 0, 1, P1, 0, 0, 0, 1),
      mk(1, 0, 0, 0, 1, P1, 0, 0, 0, 0),
      mk(-32768, 0, 0, 0, 1, N1, 0, 0, 0, 0),
      mk(0, 32767, 0, 0, 1, 0, P1, 0, 0, 0),
      mk(0, 0, -1, 0, 1, 0, 0, N1, 0, 0),
      mk(0, 0, 0, 32767, 1, 0, 0, 0, P1, 0),
      mk(0, 0, 0, -32768, 1, 0, 0, 0, N1, 0),
      mk(32767, 32767, 32767, 32767, 1, HALF, HALF, HALF, HALF, 0),
      mk(-32768, -32768, -32768, -32768, 1, -HALF, -HALF, -HALF, -HALF, 0),
      mk(3, 4, 0, 0),
      mk(-3, 0, 4, 0),
      mk(1, 1, 1, 0),
      mk(1, -1, 0, 0),
      mk(-32768, 32767, 1, -1),
      mk(32767, 1, 0, 0),
      mk(1, 32767, -32768, 0),
      mk(-1, -1, -1, -1),
      mk(2, 1, 0, 0),
      mk(16'sh5555, -16'sh2aab, 16'sh00ff, -16'sh7f00)
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 33 : ph == 1 ? 67 : 0;
      recv_stall_pct = ph == 0 ? 67 : ph == 1 ? 33 : 0;
      if (ph == 0) foreach (directed[i]) pending_words.push_back(directed[i]);
      for (int i = 0; i < 317; i++) pending_words.push_back(rand_word());
      while (pending_words.size() > 0) @(posedge clk);
    end
    while (expected_units.size() > 0) @(posedge clk);
    repeat (vsn_pkg::LAT + 10) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
